/* hw/rtl/pfa_pkg.sv */
// Shared types and constants of the page frame allocator.
// No dependencies; imported by the controller, the datapath and the top level.
package pfa_pkg;

	localparam int PFA_FRAMES  = 32;
	localparam int DIR_ENTRIES = 1024;
	localparam int DIR_AW      = $clog2(DIR_ENTRIES);
	localparam int FRAME_SHIFT = 22;
	localparam int AMOUNT_W    = 32;
	// ceil(amount / 2^FRAME_SHIFT) fits in this many bits
	localparam int NEED_W      = AMOUNT_W - FRAME_SHIFT + 1;

	typedef enum logic [1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_CHECK = 2'd2
	} func_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic              capture;   // latch request, start directory read
		logic              exec;      // apply request, load result register
		logic              clr_we;    // directory clearing write
		logic [DIR_AW-1:0] clr_addr;
	} pfa_cmd_t;

endpackage

/* hw/rtl/page_frame_allocator_core.sv */
// Page frame allocator: bitmap first-fit allocation of 4 MiB frames with a
// page directory. Top level; depends on pfa_pkg, pfa_ctrl and pfa_dp.
//
// Input channel (in_valid/in_ready) carries one request: func selects
// allocate, free or check; virtual_page indexes the directory; amount_bytes
// is used by check only. Output channel (out_valid/out_ready) returns one
// result per request: ok, frame and free_frames_now.
// A request first reads its directory entry from the synchronous memory,
// then updates bitmap, count and entry and loads the result register once
// that register is free or being emptied. in_ready is high only while no
// request is in work, so a new request waits until the last one is applied.
// After reset the directory memory is cleared one entry per cycle, all 1024
// entries, with in_ready low; frame 0 is marked used and the free count is
// FRAMES minus one.
// While the receiver stalls, the result register holds its result; the next
// request is still accepted and its result waits until the register empties.
module page_frame_allocator_core
	import pfa_pkg::*;
#(
	parameter int FRAMES = PFA_FRAMES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  logic [DIR_AW-1:0]   virtual_page,
	input  logic [AMOUNT_W-1:0] amount_bytes,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                ok,
	output logic [4:0]          frame,
	output logic [5:0]          free_frames_now
);

	pfa_cmd_t cmd;

	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	pfa_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.func            (func),
		.virtual_page    (virtual_page),
		.amount_bytes    (amount_bytes),
		.ok              (ok),
		.frame           (frame),
		.free_frames_now (free_frames_now)
	);

endmodule

/* hw/rtl/pfa_ctrl.sv */
// Controller of the page frame allocator: directory clearing pass, request
// sequencing and the result handshake. Depends on pfa_pkg.
module pfa_ctrl
	import pfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output pfa_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t            state_q;
	logic [DIR_AW-1:0] clr_addr_q;
	logic              out_valid_q;
	logic              fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	// finish only when the result register is free or being emptied
	assign fire      = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	always_comb begin
		cmd          = '0;
		cmd.capture  = in_valid && in_ready;
		cmd.exec     = fire;
		cmd.clr_we   = (state_q == ST_CLEAR);
		cmd.clr_addr = clr_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == DIR_AW'(DIR_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/pfa_dp.sv */
// Datapath of the page frame allocator: frame bitmap, free count, page
// directory memory, lowest-free search and result register. Depends on pfa_pkg.
module pfa_dp
	import pfa_pkg::*;
#(
	parameter int FRAMES = PFA_FRAMES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfa_cmd_t            cmd,
	input  logic [1:0]          func,
	input  logic [DIR_AW-1:0]   virtual_page,
	input  logic [AMOUNT_W-1:0] amount_bytes,
	output logic                ok,
	output logic [4:0]          frame,
	output logic [5:0]          free_frames_now
);

	localparam int FW = $clog2(FRAMES);
	localparam int CW = $clog2(FRAMES + 1);
	localparam int EW = FW + 1;

	// directory entry: present bit over frame number
	logic [EW-1:0]       dir_mem [DIR_ENTRIES];
	logic [EW-1:0]       rd_q;

	logic [1:0]          func_q;
	logic [DIR_AW-1:0]   page_q;
	logic [AMOUNT_W-1:0] amount_q;

	logic [FRAMES-1:0]   used_q;
	logic [CW-1:0]       count_q;

	logic                ok_q;
	logic [4:0]          frame_q;
	logic [5:0]          free_q;

	logic [FRAMES-1:0]   free_vec;
	logic [FW-1:0]       alloc_f;
	logic                found;
	logic                ent_present;
	logic [FW-1:0]       ent_frame;
	logic                ent_in_range;
	logic [NEED_W-1:0]   need;

	logic                nxt_ok;
	logic [FW-1:0]       nxt_frame;
	logic [CW-1:0]       nxt_count;
	logic [FRAMES-1:0]   nxt_used;
	logic                dir_we;
	logic [EW-1:0]       dir_wd;

	logic [FW+4:0]       frame_ext;
	logic [CW+5:0]       count_ext;

	logic                mem_we;
	logic [DIR_AW-1:0]   mem_wa;
	logic [EW-1:0]       mem_wd;

	// lowest free frame above the reserved frame 0
	always_comb begin
		free_vec    = ~used_q;
		free_vec[0] = 1'b0;
		found       = |free_vec;
		alloc_f     = '0;
		for (int i = FRAMES - 1; i >= 1; i--) begin
			if (free_vec[i]) begin
				alloc_f = FW'(i);
			end
		end
	end

	assign ent_present  = rd_q[FW];
	assign ent_frame    = rd_q[FW-1:0];
	assign ent_in_range = ({1'b0, ent_frame} < EW'(FRAMES));
	// round up to whole frames
	assign need = {1'b0, amount_q[AMOUNT_W-1:FRAME_SHIFT]}
		+ NEED_W'(|amount_q[FRAME_SHIFT-1:0]);

	always_comb begin
		nxt_ok    = 1'b0;
		nxt_frame = '0;
		nxt_count = count_q;
		nxt_used  = used_q;
		dir_we    = 1'b0;
		dir_wd    = '0;
		case (func_q)
			FUNC_ALLOC: begin
				if (found) begin
					nxt_ok            = 1'b1;
					nxt_frame         = alloc_f;
					nxt_used[alloc_f] = 1'b1;
					if (count_q != '0) begin
						nxt_count = count_q - 1'b1;
					end
					dir_we = 1'b1;
					dir_wd = {1'b1, alloc_f};
				end
			end
			FUNC_FREE: begin
				if (ent_present) begin
					nxt_ok    = 1'b1;
					nxt_frame = ent_frame;
					if (ent_in_range && used_q[ent_frame]) begin
						nxt_used[ent_frame] = 1'b0;
						nxt_count           = count_q + 1'b1;
					end
					dir_we = 1'b1;
				end
			end
			FUNC_CHECK: begin
				nxt_ok = ({{NEED_W{1'b0}}, count_q} >= {{CW{1'b0}}, need});
			end
			default: begin
				nxt_ok = 1'b0;
			end
		endcase
	end

	assign frame_ext = {5'b0, nxt_frame};
	assign count_ext = {6'b0, nxt_count};

	assign mem_we = cmd.clr_we || (cmd.exec && dir_we);
	assign mem_wa = cmd.clr_we ? cmd.clr_addr : page_q;
	assign mem_wd = cmd.clr_we ? '0 : dir_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dir_mem[mem_wa] <= mem_wd;
		end
		if (cmd.capture) begin
			rd_q     <= dir_mem[virtual_page];
			func_q   <= func;
			page_q   <= virtual_page;
			amount_q <= amount_bytes;
		end
		if (cmd.exec) begin
			ok_q    <= nxt_ok;
			frame_q <= frame_ext[4:0];
			free_q  <= count_ext[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= FRAMES'(1);
			count_q <= CW'(FRAMES - 1);
		end else if (cmd.exec) begin
			used_q  <= nxt_used;
			count_q <= nxt_count;
		end
	end

	assign ok              = ok_q;
	assign frame           = frame_q;
	assign free_frames_now = free_q;

endmodule

/* hw/rtl/pfa_chk.sv */
// Port-level checks of the page frame allocator, bound to the top level.
// Depends on page_frame_allocator_core.
module pfa_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       ok,
	input logic [4:0] frame
);

	// one request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in work");

	// a failed request reports no frame
	a_fail_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (frame == 5'd0))
		else $error("failed result carries a frame");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(ok) && $stable(frame)))
		else $error("stalled result changed");

endmodule

bind page_frame_allocator_core pfa_chk u_pfa_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.ok        (ok),
	.frame     (frame)
);
